@@ hw/rtl/gdwa_pkg.sv @@
// gdwa_pkg: request/response word types, function and status codes, register indexes
// shared by the raster disc core and its checker; the divider and the cell store do not use it
package gdwa_pkg;

  typedef struct packed {
    logic [1:0]         func;
    logic [15:0]        x_coord;
    logic [15:0]        y_coord;
    logic [15:0]        radius;
    logic [1:0]         layer_select;
    logic signed [15:0] write_value;
    logic signed [31:0] write_time;
  } req_t;

  typedef struct packed {
    logic signed [15:0] result_value;
    logic [12:0]        cells_hit;
    logic [1:0]         status;
  } rsp_t;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_MAX   = 2'd1;
  localparam logic [1:0] FUNC_MIN   = 2'd2;
  localparam logic [1:0] FUNC_MEAN  = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OUTSIDE   = 2'd1;
  localparam logic [1:0] STATUS_BAD_LAYER = 2'd2;

  localparam logic [1:0] REG_CELL_WIDTH   = 2'd0;
  localparam logic [1:0] REG_CELL_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_WORLD_WIDTH  = 2'd2;
  localparam logic [1:0] REG_WORLD_HEIGHT = 2'd3;

  localparam logic signed [15:0] Q_ONE       = 16'sh0100;
  localparam logic signed [15:0] Q_MINUS_ONE = 16'shFF00;
  localparam logic [12:0]        HIT_MAX     = 13'h1FFF;

endpackage

@@ hw/rtl/gdwa_div.sv @@
// gdwa_div: unsigned restoring divider, one quotient bit per cycle
// standalone, no package use
module gdwa_div #(
  parameter int NW = 32,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);
  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [CW-1:0] cnt;
  logic [DW-1:0] den_r;
  logic          busy;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem, quot[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CW'(NW);
        rem   <= '0;
        quot  <= num;
        den_r <= den;
      end else if (busy) begin
        if (fits) begin
          rem <= DW'(trial - {1'b0, den_r});
        end else begin
          rem <= trial[DW-1:0];
        end
        quot <= {quot[NW-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ hw/rtl/gdwa_mem.sv @@
// gdwa_mem: single-port cell store, value and timestamp, registered read
// standalone, no package use
module gdwa_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic               clk,
  input  logic [AW-1:0]      addr,
  input  logic               we,
  input  logic signed [15:0] wvalue,
  input  logic signed [31:0] wtime,
  output logic signed [15:0] rvalue
);
  logic signed [15:0] value_mem [DEPTH];
  logic signed [31:0] time_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      value_mem[addr] <= wvalue;
      time_mem[addr]  <= wtime;
    end
    rvalue <= value_mem[addr];
  end
endmodule

@@ hw/rtl/grid_disc_write_and_aggregate_core.sv @@
// grid_disc_write_and_aggregate_core: layered raster disc writer and max/min/mean aggregator
// uses gdwa_pkg, gdwa_div (shared divider), gdwa_mem (cell store)
// sequence: divisions for origin column, origin row and (nonzero radius) spiral side, then a
//   write or read per visited cell, a disc test per spiral position (one shared multiplier)
// throughput: one request at a time, set by the spiral walk length b*b
// reset: synchronous; a clearing pass writes every cell, during which no request is
//   taken (register writes still land)
module grid_disc_write_and_aggregate_core
  import gdwa_pkg::*;
#(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64,
  parameter int LAYERS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  // derived sizes
  localparam int MAXG  = (GRID_W > GRID_H) ? GRID_W : GRID_H;
  localparam int CAP   = 2 * MAXG;
  localparam int BW    = $clog2(CAP + 1);
  localparam int ITW   = $clog2(CAP * CAP + 1);
  localparam int CPL   = GRID_W * GRID_H;
  localparam int DEPTH = LAYERS * CPL;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(CPL + 1);
  localparam int SUM_W = CNT_W + 16;
  localparam int GXW   = $clog2(GRID_W);
  localparam int GYW   = $clog2(GRID_H);
  localparam int SPW   = $clog2(MAXG) + 3;
  localparam int MAGW  = SPW - 1;
  localparam int EXW   = MAGW + 11;
  localparam int MW    = (EXW > 16) ? EXW : 16;
  localparam int PW    = 2 * MW;
  localparam int NW    = (SUM_W + 2 > 18) ? SUM_W + 2 : 18;
  localparam int DW    = (CNT_W + 2 > 12) ? CNT_W + 2 : 12;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DX, S_DY, S_DB, S_R2, S_BB, S_RD, S_ACC, S_CHK,
    S_M1, S_M2, S_M3, S_M4, S_CMP, S_ADV, S_FIN, S_DM, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [10:0] cell_width, cell_height;
  logic [15:0] world_width, world_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width   <= 11'd1;
      cell_height  <= 11'd1;
      world_width  <= 16'd64;
      world_height <= 16'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELL_WIDTH:   cell_width   <= cfg_data[10:0];
        REG_CELL_HEIGHT:  cell_height  <= cfg_data[10:0];
        REG_WORLD_WIDTH:  world_width  <= cfg_data;
        REG_WORLD_HEIGHT: world_height <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [10:0] rw, rh, minc;
  assign rw   = (cell_width == '0) ? 11'd1 : cell_width;
  assign rh   = (cell_height == '0) ? 11'd1 : cell_height;
  assign minc = (rw < rh) ? rw : rh;

  // latched request
  logic [1:0]         func;
  logic [15:0]        x_in, y_in, radius;
  logic [1:0]         layer;
  logic signed [15:0] wvalue;
  logic signed [31:0] wtime;

  // walk state
  logic [GXW-1:0]        ox, cur_x;
  logic [GYW-1:0]        oy, cur_y;
  logic [BW-1:0]         bsize;
  logic [ITW-1:0]        iters, step;
  logic [31:0]           r2;
  logic signed [SPW-1:0] xx, yy;
  logic signed [1:0]     dx, dy;
  logic                  sp_on;
  logic [EXW-1:0]        ex, ey;
  logic [PW-1:0]         ex2, ey2;

  // aggregation
  logic [CNT_W-1:0]         cnt;
  logic signed [15:0]       acc_max, acc_min;
  logic signed [SUM_W-1:0]  acc_sum;

  // clearing pass
  logic [AW-1:0]  clr_a;
  logic [GXW-1:0] clr_x;
  logic [GYW-1:0] clr_y;

  // shared multiplier
  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] prod;
  logic [MAGW-1:0] xmag, ymag;

  assign xmag = MAGW'(xx[SPW-1] ? -xx : xx);
  assign ymag = MAGW'(yy[SPW-1] ? -yy : yy);

  always_comb begin
    case (state)
      S_R2: begin mul_a = MW'(radius); mul_b = MW'(radius); end
      S_BB: begin mul_a = MW'(bsize);  mul_b = MW'(bsize);  end
      S_M1: begin mul_a = MW'(xmag);   mul_b = MW'(rw);     end
      S_M2: begin mul_a = MW'(ex);     mul_b = MW'(ex);     end
      S_M3: begin mul_a = MW'(ymag);   mul_b = MW'(rh);     end
      S_M4: begin mul_a = MW'(ey);     mul_b = MW'(ey);     end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign prod = mul_a * mul_b;

  // shared divider
  logic          dv_start, dv_done, dv_run;
  logic [NW-1:0] dv_num, dv_quot;
  logic [DW-1:0] dv_den;
  logic          mean_neg;
  logic [SUM_W-1:0] mean_mag;

  assign mean_neg = acc_sum[SUM_W-1];
  assign mean_mag = mean_neg ? SUM_W'(-acc_sum) : SUM_W'(acc_sum);

  always_comb begin
    case (state)
      S_DX: begin dv_num = NW'(x_in); dv_den = DW'(rw); end
      S_DY: begin dv_num = NW'(y_in); dv_den = DW'(rh); end
      S_DB: begin dv_num = NW'({radius, 1'b0}); dv_den = DW'(minc); end
      default: begin
        dv_num = NW'({mean_mag, 1'b0}) + NW'(cnt);
        dv_den = DW'({cnt, 1'b0});
      end
    endcase
  end
  assign dv_start = !dv_run &&
                    (state == S_DX || state == S_DY || state == S_DB || state == S_DM);

  gdwa_div #(.NW(NW), .DW(DW)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(dv_start),
    .num  (dv_num),
    .den  (dv_den),
    .done (dv_done),
    .quot (dv_quot)
  );

  // cell store
  logic [AW-1:0]      vis_a, mem_a;
  logic               mem_we;
  logic signed [15:0] mem_wv, mem_rv;
  logic signed [31:0] mem_wt;
  logic               clr_right;

  assign vis_a = AW'(layer) * AW'(CPL) + AW'(cur_x) * AW'(GRID_H) + AW'(cur_y);
  assign clr_right = {clr_x, 1'b0} > (GXW + 1)'(GRID_W);

  always_comb begin
    if (state == S_CLR) begin
      mem_a  = clr_a;
      mem_we = 1'b1;
      mem_wv = clr_right ? Q_MINUS_ONE : Q_ONE;
      mem_wt = clr_right ? -32'sd1 : 32'sd0;
    end else begin
      mem_a  = vis_a;
      mem_we = (state == S_RD) && (func == FUNC_WRITE);
      mem_wv = wvalue;
      mem_wt = wtime;
    end
  end

  gdwa_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .addr  (mem_a),
    .we    (mem_we),
    .wvalue(mem_wv),
    .wtime (mem_wt),
    .rvalue(mem_rv)
  );

  // spiral position under test
  logic signed [SPW:0] cx, cy;
  logic                in_grid, turn;

  assign cx = (SPW + 1)'(signed'({1'b0, ox})) + (SPW + 1)'(xx);
  assign cy = (SPW + 1)'(signed'({1'b0, oy})) + (SPW + 1)'(yy);
  assign in_grid = (xx != '0 || yy != '0) && !cx[SPW] && !cy[SPW] &&
                   (cx < (SPW + 1)'(GRID_W)) && (cy < (SPW + 1)'(GRID_H));
  assign turn = (xx == yy) || (xx < 0 && xx == -yy) || (xx > 0 && xx == SPW'(1) - yy);

  // request dispatch
  logic accept;
  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);

  logic signed [15:0] sv;
  assign sv = mem_rv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      rsp_valid <= 1'b0;
      dv_run    <= 1'b0;
      clr_a     <= '0;
      clr_x     <= '0;
      clr_y     <= '0;
    end else begin
      if (dv_start) dv_run <= 1'b1;
      if (dv_done)  dv_run <= 1'b0;
      case (state)
        S_CLR: begin
          // sweep every cell to its reset value, y fastest
          clr_a <= clr_a + 1'b1;
          if (clr_y == GYW'(GRID_H - 1)) begin
            clr_y <= '0;
            clr_x <= (clr_x == GXW'(GRID_W - 1)) ? '0 : clr_x + 1'b1;
          end else begin
            clr_y <= clr_y + 1'b1;
          end
          if (clr_a == AW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            func   <= req.func;
            x_in   <= req.x_coord;
            y_in   <= req.y_coord;
            radius <= req.radius;
            layer  <= req.layer_select;
            wvalue <= req.write_value;
            wtime  <= req.write_time;
            cnt    <= '0;
            acc_sum <= '0;
            sp_on  <= 1'b0;
            rsp.result_value <= '0;
            rsp.cells_hit    <= '0;
            if (req.x_coord > world_width || req.y_coord > world_height) begin
              rsp.status <= STATUS_OUTSIDE;
              rsp_valid  <= 1'b1;
              state      <= S_OUT;
            end else if (32'(req.layer_select) >= 32'(LAYERS)) begin
              rsp.status <= STATUS_BAD_LAYER;
              rsp_valid  <= 1'b1;
              state      <= S_OUT;
            end else begin
              rsp.status <= STATUS_OK;
              state      <= S_DX;
            end
          end
        end
        S_DX: begin
          // origin column: floor(x / cell_width), clamped to the grid
          if (dv_done) begin
            ox    <= (dv_quot > NW'(GRID_W - 1)) ? GXW'(GRID_W - 1) : GXW'(dv_quot);
            state <= S_DY;
          end
        end
        S_DY: begin
          if (dv_done) begin
            oy    <= (dv_quot > NW'(GRID_H - 1)) ? GYW'(GRID_H - 1) : GYW'(dv_quot);
            cur_x <= ox;
            cur_y <= (dv_quot > NW'(GRID_H - 1)) ? GYW'(GRID_H - 1) : GYW'(dv_quot);
            xx    <= '0;
            yy    <= '0;
            dx    <= 2'sd0;
            dy    <= -2'sd1;
            step  <= '0;
            if (radius == '0) begin
              iters <= '0;
              state <= S_RD;
            end else begin
              state <= S_DB;
            end
          end
        end
        S_DB: begin
          // spiral side b = 2r / min cell size, capped
          if (dv_done) begin
            bsize <= (dv_quot > NW'(CAP)) ? BW'(CAP) : BW'(dv_quot);
            state <= S_R2;
          end
        end
        S_R2: begin
          r2    <= 32'(prod);
          state <= S_BB;
        end
        S_BB: begin
          iters <= ITW'(prod);
          state <= S_RD;
        end
        S_RD: begin
          // write lands here; a query's read data shows up next cycle
          if (func == FUNC_WRITE) begin
            cnt   <= cnt + 1'b1;
            state <= sp_on ? S_ADV : S_CHK;
            sp_on <= 1'b1;
          end else begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (cnt == '0 || sv > acc_max) acc_max <= sv;
          if (cnt == '0 || sv < acc_min) acc_min <= sv;
          acc_sum <= acc_sum + SUM_W'(sv);
          cnt     <= cnt + 1'b1;
          state   <= sp_on ? S_ADV : S_CHK;
          sp_on   <= 1'b1;
        end
        S_CHK: begin
          if (step == iters) begin
            state <= S_FIN;
          end else if (in_grid) begin
            cur_x <= GXW'(cx);
            cur_y <= GYW'(cy);
            state <= S_M1;
          end else begin
            state <= S_ADV;
          end
        end
        S_M1: begin ex  <= EXW'(prod); state <= S_M2; end
        S_M2: begin ex2 <= prod;       state <= S_M3; end
        S_M3: begin ey  <= EXW'(prod); state <= S_M4; end
        S_M4: begin ey2 <= prod;       state <= S_CMP; end
        S_CMP: begin
          // disc test against r squared
          if ((PW + 1)'(ex2) + (PW + 1)'(ey2) <= (PW + 1)'(r2)) begin
            state <= S_RD;
          end else begin
            state <= S_ADV;
          end
        end
        S_ADV: begin
          if (turn) begin
            dx <= -dy;
            dy <= dx;
            xx <= xx - SPW'(dy);
            yy <= yy + SPW'(dx);
          end else begin
            xx <= xx + SPW'(dx);
            yy <= yy + SPW'(dy);
          end
          step  <= step + 1'b1;
          state <= S_CHK;
        end
        S_FIN: begin
          rsp.cells_hit <= (32'(cnt) > 32'(HIT_MAX)) ? HIT_MAX : 13'(cnt);
          case (func)
            FUNC_MAX: begin
              rsp.result_value <= acc_max;
              rsp_valid <= 1'b1;
              state <= S_OUT;
            end
            FUNC_MIN: begin
              rsp.result_value <= acc_min;
              rsp_valid <= 1'b1;
              state <= S_OUT;
            end
            FUNC_MEAN: state <= S_DM;
            default: begin
              rsp_valid <= 1'b1;
              state <= S_OUT;
            end
          endcase
        end
        S_DM: begin
          // mean rounded half away from zero: (2|s| + n) / 2n, sign restored
          if (dv_done) begin
            rsp.result_value <= mean_neg ? -16'(dv_quot) : 16'(dv_quot);
            rsp_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!rsp_stall) begin
            rsp_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hw/rtl/gdwa_chk.sv @@
// gdwa_chk: port-level checks for the raster disc core
// uses gdwa_pkg; bound to grid_disc_write_and_aggregate_core
module gdwa_chk
  import gdwa_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input req_t        req,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input rsp_t        rsp,
  input logic        cfg_we,
  input logic [1:0]  cfg_index,
  input logic [15:0] cfg_data
);
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request taken while a response is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("no busy cycle after a request");

  a_error_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != STATUS_OK |-> rsp.result_value == '0 && rsp.cells_hit == '0)
    else $error("error response carries data");

  a_ok_hits: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STATUS_OK |-> rsp.cells_hit != '0)
    else $error("ok response with no cell visited");
endmodule

bind grid_disc_write_and_aggregate_core gdwa_chk u_gdwa_chk (.*);

@@ bench/gdwa_checker.sv @@
// gdwa_checker: watches the request, response and register channels of the raster disc core,
// predicts every response from its own copy of the cells and registers, and counts mismatches
// depends on gdwa_pkg
`timescale 1ns / 1ps

module gdwa_checker
  import gdwa_pkg::*;
#(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64,
  parameter int LAYERS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  req_t        req,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_t        rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          pending,
  output int          errors
);

  localparam int CELLS = GRID_W * GRID_H;

  logic signed [15:0] cell_q [LAYERS*CELLS];
  logic [31:0]        cell_stamp [LAYERS*CELLS];
  logic [10:0]        cw_reg, ch_reg;
  logic [15:0]        ww_reg, wh_reg;
  rsp_t               want_q [$];
  int                 checked;

  initial begin
    errors  = 0;
    checked = 0;
  end

  assign pending = want_q.size();

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (2 * n + d) / (2 * d);
    return -((-2 * n + d) / (2 * d));
  endfunction

  function automatic int origin_of(longint coord, longint size, int lim);
    longint c;
    c = round_div(2 * coord - size, 2 * size);
    if (c < 0) c = 0;
    if (c > lim - 1) c = lim - 1;
    return int'(c);
  endfunction

  // rejects off-world or bad-layer words, else walks the spiral and writes or folds each cell inside the disc
  function automatic rsp_t predict_disc(req_t w);
    rsp_t   o;
    longint rw, rh, minc, b, cap, steps, r2, ex, ey, sum;
    int     ox, oy, xx, yy, dx, dy, t, cx, cy, base, hits, cnt, mx, mn, v, idx;
    o = '0;
    if (w.x_coord > ww_reg || w.y_coord > wh_reg) begin
      o.status = STATUS_OUTSIDE;
      return o;
    end
    if (int'(w.layer_select) >= LAYERS) begin
      o.status = STATUS_BAD_LAYER;
      return o;
    end
    rw = (cw_reg == 0) ? 1 : cw_reg;
    rh = (ch_reg == 0) ? 1 : ch_reg;
    ox = origin_of(w.x_coord, rw, GRID_W);
    oy = origin_of(w.y_coord, rh, GRID_H);
    base = int'(w.layer_select) * CELLS;
    sum = 0; cnt = 0; mx = -32768; mn = 32767; hits = 0;
    minc = (rw < rh) ? rw : rh;
    b = (2 * longint'(w.radius)) / minc;
    cap = 2 * ((GRID_W > GRID_H) ? GRID_W : GRID_H);
    if (b > cap) b = cap;
    steps = (w.radius == 0) ? 0 : b * b;
    r2 = longint'(w.radius) * longint'(w.radius);
    xx = 0; yy = 0; dx = 0; dy = -1;
    // origin first, then the spiral with the origin skipped
    for (longint i = -1; i < steps; i++) begin
      if (i < 0) begin
        cx = ox; cy = oy;
      end else begin
        cx = xx + ox; cy = yy + oy;
        ex = xx * rw; ey = yy * rh;
        if ((xx == 0 && yy == 0) || cx < 0 || cx >= GRID_W || cy < 0 || cy >= GRID_H ||
            ex * ex + ey * ey > r2)
          cx = -1;
        if (xx == yy || (xx < 0 && xx == -yy) || (xx > 0 && xx == 1 - yy)) begin
          t = dx; dx = -dy; dy = t;
        end
        xx += dx; yy += dy;
      end
      if (cx >= 0) begin
        idx = base + cx * GRID_H + cy;
        hits++;
        if (w.func == FUNC_WRITE) begin
          cell_q[idx] = w.write_value;
          cell_stamp[idx] = w.write_time;
        end else begin
          v = cell_q[idx];
          if (v > mx) mx = v;
          if (v < mn) mn = v;
          sum += v;
          cnt++;
        end
      end
    end
    case (w.func)
      FUNC_MAX:  o.result_value = mx[15:0];
      FUNC_MIN:  o.result_value = mn[15:0];
      FUNC_MEAN: o.result_value = 16'(round_div(sum, cnt));
      default:   o.result_value = '0;
    endcase
    o.cells_hit = (hits > HIT_MAX) ? HIT_MAX : 13'(hits);
    o.status = STATUS_OK;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on response %0d: %s got %0d expected %0d", checked, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < LAYERS * CELLS; i++) begin
        if (2 * ((i % CELLS) / GRID_H) > GRID_W) begin
          cell_q[i] = Q_MINUS_ONE;
          cell_stamp[i] = '1;
        end else begin
          cell_q[i] = Q_ONE;
          cell_stamp[i] = '0;
        end
      end
      cw_reg = 11'd1; ch_reg = 11'd1; ww_reg = 16'd64; wh_reg = 16'd64;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CELL_WIDTH:   cw_reg = cfg_data[10:0];
          REG_CELL_HEIGHT:  ch_reg = cfg_data[10:0];
          REG_WORLD_WIDTH:  ww_reg = cfg_data;
          REG_WORLD_HEIGHT: wh_reg = cfg_data;
          default: ;
        endcase
      end
      if (rsp_valid && !rsp_stall) begin
        if (want_q.size() == 0) begin
          $display("response word with nothing expected");
          errors++;
        end else begin
          want = want_q.pop_front();
          if (rsp.result_value !== want.result_value)
            report_mismatch("result_value", rsp.result_value, want.result_value);
          if (rsp.cells_hit !== want.cells_hit)
            report_mismatch("cells_hit", rsp.cells_hit, want.cells_hit);
          if (rsp.status !== want.status)
            report_mismatch("status", rsp.status, want.status);
        end
        checked++;
      end
      if (req_valid && !req_stall)
        want_q = {want_q, predict_disc(req)};
    end
  end

endmodule

@@ bench/tb_grid_disc_write_and_aggregate_core.sv @@
// tb_grid_disc_write_and_aggregate_core: stimulus and verdict for the raster disc core
// depends on gdwa_pkg, grid_disc_write_and_aggregate_core and gdwa_checker
`timescale 1ns / 1ps

module tb_grid_disc_write_and_aggregate_core;
  import gdwa_pkg::*;

  // longest quiet stretch: a full capped spiral (128*128 positions)
  // or the clearing pass after reset, taken several times over
  localparam int QUIET_LIMIT = 600000;

  logic        clk = 0;
  logic        rst = 1;
  logic        req_valid = 0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 0;
  rsp_t        rsp;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = REG_CELL_WIDTH;
  logic [15:0] cfg_data = '0;
  int          pending, errors;
  int          tx_idle_pct = 0, rx_idle_pct = 0;
  int          quiet = 0;
  int          words_sent = 0;
  int          func_count [4];
  int          settings_run = 0;

  always #5 clk = ~clk;

  grid_disc_write_and_aggregate_core i_dut (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .cfg_we, .cfg_index, .cfg_data
  );

  gdwa_checker i_checker (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .cfg_we, .cfg_index, .cfg_data, .pending, .errors
  );

  // receiver stalls at random, changed on the falling edge
  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // watchdog: counts cycles in which neither channel moves a word
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // entered and left at a falling edge; valid stays high across back-to-back words
  task automatic send_word(req_t w);
    if ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 0;
      @(negedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(negedge clk);
    end
    req <= w;
    req_valid <= 1;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
    words_sent++;
    func_count[w.func]++;
  endtask

  task automatic drain;
    req_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic load_regs(logic [15:0] cw, logic [15:0] ch, logic [15:0] ww, logic [15:0] wh);
    cfg_we <= 1; cfg_index <= REG_CELL_WIDTH;   cfg_data <= cw; @(negedge clk);
    cfg_index <= REG_CELL_HEIGHT;  cfg_data <= ch; @(negedge clk);
    cfg_index <= REG_WORLD_WIDTH;  cfg_data <= ww; @(negedge clk);
    cfg_index <= REG_WORLD_HEIGHT; cfg_data <= wh; @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
    settings_run++;
  endtask

  function automatic req_t disc_word(logic [1:0] f, int x, int y, int r, int l,
                                     logic [15:0] v, logic [31:0] ts);
    req_t w;
    w.func = f; w.x_coord = 16'(x); w.y_coord = 16'(y); w.radius = 16'(r);
    w.layer_select = 2'(l); w.write_value = v; w.write_time = ts;
    return w;
  endfunction

  // mostly small discs so the walk stays short, a few wide ones, some off-world centers
  function automatic req_t random_word(int cw, int ch, int ww, int wh);
    req_t w;
    int   minc, r;
    minc = (cw == 0 ? 1 : cw) < (ch == 0 ? 1 : ch) ? (cw == 0 ? 1 : cw) : (ch == 0 ? 1 : ch);
    w.func = 2'($urandom_range(3));
    w.layer_select = 2'($urandom_range(3));
    w.x_coord = 16'(($urandom_range(99) < 8) ? $urandom_range(65535) : $urandom_range(ww));
    w.y_coord = 16'(($urandom_range(99) < 8) ? $urandom_range(65535) : $urandom_range(wh));
    if ($urandom_range(99) < 15) r = 0;
    else if ($urandom_range(99) < 3) r = $urandom_range(minc * 12);
    else r = $urandom_range(1, minc * 3);
    w.radius = 16'((r > 65535) ? 65535 : r);
    w.write_value = 16'($urandom_range(65535));
    w.write_time = $urandom();
    return w;
  endfunction

  initial begin
    int cfg_set [5][4];
    cfg_set = '{'{1, 1, 64, 64}, '{3, 2, 200, 150}, '{1024, 1024, 65535, 65535},
                '{0, 5, 65535, 1}, '{7, 1, 1000, 70}};
    foreach (func_count[i]) func_count[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);
    load_regs(1, 1, 64, 64);

    // directed: corner and edge centers, every function, both halves of the reset pattern,
    // off-world rejection, rounding of the mean and the capped spiral
    send_word(disc_word(FUNC_MAX, 0, 0, 0, 0, 0, 0));
    send_word(disc_word(FUNC_WRITE, 0, 0, 0, 0, 16'h7FFF, 32'h7FFFFFFF));
    send_word(disc_word(FUNC_MAX, 0, 0, 1, 0, 0, 0));
    send_word(disc_word(FUNC_MIN, 64, 64, 0, 0, 0, 0));
    send_word(disc_word(FUNC_MEAN, 32, 10, 3, 1, 0, 0));
    send_word(disc_word(FUNC_MEAN, 33, 10, 2, 1, 0, 0));
    send_word(disc_word(FUNC_WRITE, 40, 40, 3, 2, 16'h8000, 32'h80000000));
    send_word(disc_word(FUNC_MIN, 40, 40, 4, 2, 0, 0));
    send_word(disc_word(FUNC_MEAN, 40, 40, 5, 2, 0, 0));
    send_word(disc_word(FUNC_MAX, 65, 3, 2, 0, 0, 0));
    send_word(disc_word(FUNC_MEAN, 3, 65, 2, 0, 0, 0));
    send_word(disc_word(FUNC_WRITE, 65535, 65535, 65535, 3, 16'h1234, 32'hFFFFFFFF));
    send_word(disc_word(FUNC_WRITE, 20, 30, 65535, 3, 16'hFFFF, 32'h0));
    send_word(disc_word(FUNC_WRITE, 10, 10, 6, 3, 16'h0081, 32'h5555AAAA));
    send_word(disc_word(FUNC_MEAN, 12, 10, 7, 3, 0, 0));
    send_word(disc_word(FUNC_MAX, 63, 0, 2, 3, 0, 0));
    drain();

    for (int p = 0; p < 5; p++) begin
      load_regs(16'(cfg_set[p][0]), 16'(cfg_set[p][1]), 16'(cfg_set[p][2]),
                16'(cfg_set[p][3]));
      for (int n = 0; n < 207; n++) begin
        case (n / 69)
          0: begin tx_idle_pct = 23; rx_idle_pct = 74; end
          1: begin tx_idle_pct = 74; rx_idle_pct = 23; end
          default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
        endcase
        send_word(random_word(cfg_set[p][0], cfg_set[p][1], cfg_set[p][2], cfg_set[p][3]));
      end
      drain();
    end

    $display("sent %0d request words over %0d register settings", words_sent, settings_run);
    $display("writes %0d, max %0d, min %0d, mean %0d", func_count[FUNC_WRITE],
             func_count[FUNC_MAX], func_count[FUNC_MIN], func_count[FUNC_MEAN]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/gdwa_pkg.sv
hw/rtl/gdwa_div.sv
hw/rtl/gdwa_mem.sv
hw/rtl/grid_disc_write_and_aggregate_core.sv
hw/rtl/gdwa_chk.sv
bench/gdwa_checker.sv
bench/tb_grid_disc_write_and_aggregate_core.sv
